// ===== hdl/cst_pkg.sv =====
`timescale 1ns / 1ps

package cst_pkg;

    localparam int NUM_SEM         = 16;
    localparam int WAIT_DEPTH      = 16;
    localparam int THREAD_BITS     = 8;
    localparam int MAX_COUNT_RESET = 10;

    localparam int ID_W    = 4;
    localparam int CNT_W   = 8;
    localparam int SIDX_W  = $clog2(NUM_SEM);
    localparam int ALLOC_W = $clog2(NUM_SEM + 1);
    localparam int WPTR_W  = $clog2(WAIT_DEPTH);
    localparam int WLEN_W  = $clog2(WAIT_DEPTH + 1);
    localparam int MEM_D   = NUM_SEM * WAIT_DEPTH;
    localparam int MEM_AW  = $clog2(MEM_D);

    typedef enum logic [1:0] {
        MODE_CREATE = 2'd0,
        MODE_TAKE   = 2'd1,
        MODE_GIVE   = 2'd2,
        MODE_DELETE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BLOCKED = 3'd1,
        ST_NO_ID   = 3'd2,
        ST_WAITERS = 3'd3,
        ST_BAD_ID  = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

endpackage

// ===== hdl/counting_semaphore_table_unit.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: mode[1:0]; tdata: sem_id, thread_id, initial_full
// m_axis    out  tdata: status, new_sem_id, wake_valid, wake_thread
// cfg       in   i_cfg_we / i_cfg_wdata: max_count
//
// One operation per cycle while the result beat is taken.
// Stage one reads and updates the semaphore table in flops; stage two holds
// the result and the registered read of the wait-queue memory.
// While the result beat is not taken, an empty stage one still takes one beat
// and holds it; s_axis_tready falls once both stages are full.
// i_rst_n is synchronous; the wait-queue memory is not cleared and needs no sweep.
module counting_semaphore_table_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [cst_pkg::CNT_W-1:0] i_cfg_wdata,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,  // sem_id, thread_id, initial_full
    input  logic [1:0]                s_axis_tuser,  // mode[1:0]
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata   // status, new_sem_id, wake_valid, wake_thread
);
    import cst_pkg::*;

    // stage one: input register
    logic                     r_s1_valid;
    t_mode                    r_mode;
    logic [ID_W-1:0]          r_id;
    logic [THREAD_BITS-1:0]   r_thread;
    logic                     r_full;

    // stage two: result register
    logic                     r_o_valid;
    t_status                  r_status;
    logic [ID_W-1:0]          r_new_id;
    logic                     r_wake_v;
    logic [THREAD_BITS-1:0]   r_rd;

    logic [CNT_W-1:0]         r_max;
    logic [ALLOC_W-1:0]       r_alloc;
    logic                     r_valid [NUM_SEM];
    logic [CNT_W-1:0]         r_count [NUM_SEM];
    logic [WPTR_W-1:0]        r_head  [NUM_SEM];
    logic [WLEN_W-1:0]        r_len   [NUM_SEM];
    logic [THREAD_BITS-1:0]   mem     [MEM_D];

    logic                     s2_load, s1_fire;
    logic [SIDX_W-1:0]        idx, aidx;
    logic                     bad_id;
    logic [CNT_W-1:0]         cnt;
    logic [WPTR_W-1:0]        hd, hd_next, slot;
    logic [WLEN_W-1:0]        len;
    logic [WLEN_W:0]          slot_sum;
    logic [MEM_AW-1:0]        wr_addr, rd_addr;
    logic                     do_create, do_dec, do_queue, do_wake, do_inc, do_delete;
    t_status                  n_status;
    logic [ID_W-1:0]          n_new_id;

    assign s2_load       = !r_o_valid || m_axis_tready;
    assign s1_fire       = r_s1_valid && s2_load;
    assign s_axis_tready = !r_s1_valid || s2_load;

    assign idx    = r_id[SIDX_W-1:0];
    assign aidx   = r_alloc[SIDX_W-1:0];
    assign bad_id = (32'(r_id) >= 32'(NUM_SEM)) || !r_valid[idx];
    assign cnt    = r_count[idx];
    assign hd     = r_head[idx];
    assign len    = r_len[idx];

    // tail slot wraps at most once since head is below the depth and length is at most the depth
    assign slot_sum = (WLEN_W+1)'(hd) + (WLEN_W+1)'(len);
    assign slot     = (slot_sum >= (WLEN_W+1)'(WAIT_DEPTH))
                    ? WPTR_W'(slot_sum - (WLEN_W+1)'(WAIT_DEPTH)) : WPTR_W'(slot_sum);
    assign hd_next  = (hd == WPTR_W'(WAIT_DEPTH - 1)) ? '0 : hd + 1'b1;
    assign wr_addr  = MEM_AW'(idx) * MEM_AW'(WAIT_DEPTH) + MEM_AW'(slot);
    assign rd_addr  = MEM_AW'(idx) * MEM_AW'(WAIT_DEPTH) + MEM_AW'(hd);

    always_comb begin
        do_create = 1'b0;
        do_dec    = 1'b0;
        do_queue  = 1'b0;
        do_wake   = 1'b0;
        do_inc    = 1'b0;
        do_delete = 1'b0;
        n_status  = ST_OK;
        n_new_id  = '0;
        if (r_mode == MODE_CREATE) begin
            if (32'(r_alloc) >= 32'(NUM_SEM)) begin
                n_status = ST_NO_ID;
            end else begin
                do_create = 1'b1;
                n_new_id  = ID_W'(r_alloc);
            end
        end else if (bad_id) begin
            n_status = ST_BAD_ID;
        end else begin
            unique case (r_mode)
                MODE_TAKE: begin
                    if (cnt != '0) begin
                        do_dec = 1'b1;
                    end else if (32'(len) >= 32'(WAIT_DEPTH)) begin
                        n_status = ST_FULL;
                    end else begin
                        do_queue = 1'b1;
                        n_status = ST_BLOCKED;
                    end
                end
                MODE_GIVE: begin
                    if (len != '0) begin
                        do_wake = 1'b1;
                    end else if (cnt >= r_max) begin
                        n_status = ST_FULL;
                    end else begin
                        do_inc = 1'b1;
                    end
                end
                MODE_DELETE: begin
                    if (len != '0) begin
                        n_status = ST_WAITERS;
                    end else begin
                        do_delete = 1'b1;
                    end
                end
                default: begin
                    n_status = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max <= CNT_W'(MAX_COUNT_RESET);
        end else if (i_cfg_we) begin
            r_max <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_mode   <= t_mode'(s_axis_tuser);
            r_id     <= s_axis_tdata[3:0];
            r_thread <= s_axis_tdata[11:4];
            r_full   <= s_axis_tdata[12];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc <= '0;
            for (int k = 0; k < NUM_SEM; k++) begin
                r_valid[k] <= 1'b0;
                r_count[k] <= '0;
                r_head[k]  <= '0;
                r_len[k]   <= '0;
            end
        end else if (s1_fire) begin
            if (do_create) begin
                r_alloc        <= r_alloc + 1'b1;
                r_valid[aidx]  <= 1'b1;
                r_count[aidx]  <= r_full ? r_max : '0;
                r_head[aidx]   <= '0;
                r_len[aidx]    <= '0;
            end
            if (do_dec) begin
                r_count[idx] <= cnt - 1'b1;
            end
            if (do_inc) begin
                r_count[idx] <= cnt + 1'b1;
            end
            if (do_queue) begin
                r_len[idx] <= len + 1'b1;
            end
            if (do_wake) begin
                r_head[idx] <= hd_next;
                r_len[idx]  <= len - 1'b1;
            end
            if (do_delete) begin
                r_valid[idx] <= 1'b0;
                r_count[idx] <= '0;
                r_head[idx]  <= '0;
                r_len[idx]   <= '0;
            end
        end
    end

    // wait-queue memory: at most one write and one registered read per cycle, both only when stage one fires
    always_ff @(posedge i_clk) begin
        if (s1_fire && do_queue) begin
            mem[wr_addr] <= r_thread;
        end
        if (s1_fire) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s2_load) begin
            r_o_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_status <= n_status;
            r_new_id <= n_new_id;
            r_wake_v <= do_wake;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {(r_wake_v ? r_rd : {THREAD_BITS{1'b0}}), r_wake_v, r_new_id,
                            r_status};

endmodule

// ===== hdl/cst_checker.sv =====
`timescale 1ns / 1ps

module cst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import cst_pkg::*;

    logic [2:0] status;
    assign status = m_axis_tdata[2:0];

    // a result beat held back must stay offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result beat dropped while stalled");

    a_wake_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[7] |-> status == ST_OK)
        else $error("wake reported with non-ok status");

    a_wake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[7] |-> m_axis_tdata[15:8] == '0)
        else $error("wake thread not zero without wake");

    a_newid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && status != ST_OK |-> m_axis_tdata[6:3] == '0)
        else $error("new id given on failed operation");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> status <= ST_FULL)
        else $error("status code out of range");

endmodule

bind counting_semaphore_table_unit cst_checker u_cst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
